@@ hdl/hcbe_pkg.sv @@
// Shared constants, types and control codes for the Hill cipher block encryptor.
`default_nettype none
package hcbe_pkg;

	localparam int LETTER_W   = 5;
	localparam int ENTRY_W    = 5;
	localparam int ROW_W      = 20;
	localparam int KEY_ROWS   = 4;
	localparam int BS_W       = 3;
	localparam int IDX_W      = 3;
	localparam int BYTE_W     = 8;
	// Column sum bound: 4 * 31 * 31 = 3844
	localparam int SUM_W      = 12;
	localparam int RECIP_W    = 12;
	localparam int RECIP_SHIFT = 16;
	localparam int MUL_W      = SUM_W + RECIP_W;
	localparam int QUOT_W     = MUL_W - RECIP_SHIFT;

	localparam logic [LETTER_W-1:0] LETTER_MOD = LETTER_W'(26);
	localparam logic [LETTER_W-1:0] PAD_LETTER = LETTER_W'(25);
	// ceil(2^16 / 26); exact quotient for every sum below 4096
	localparam logic [RECIP_W-1:0]  RECIP      = RECIP_W'(2521);

	localparam logic [BS_W-1:0]  BLOCK_SIZE_RST = BS_W'(2);

	localparam logic [IDX_W-1:0] REG_BLOCK_SIZE = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_KEY_ROW0   = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_KEY_ROW1   = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_KEY_ROW2   = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_KEY_ROW3   = IDX_W'(4);

	typedef logic [KEY_ROWS-1:0][ROW_W-1:0] key_rows_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SUM  = 4'b0010,
		ST_RED  = 4'b0100,
		ST_SEND = 4'b1000
	} state_t;

	typedef struct packed {
		logic take;
		logic sum_en;
		logic red_en;
		logic col_inc;
		logic col_clr;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic last_col;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ hdl/hcbe_cfg.sv @@
// Configuration registers: block size and key matrix rows.
`default_nettype none
module hcbe_cfg #(
	parameter int MAX_BLOCK = 4,
	parameter int CNT_W     = $clog2(MAX_BLOCK + 1)
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [hcbe_pkg::IDX_W-1:0]     cfg_index,
	input  wire  [hcbe_pkg::ROW_W-1:0]     cfg_data,
	output logic [CNT_W-1:0]               blk_n,
	output hcbe_pkg::key_rows_t            key_rows
);

	logic [hcbe_pkg::BS_W-1:0] block_size_q;
	hcbe_pkg::key_rows_t       key_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= hcbe_pkg::BLOCK_SIZE_RST;
			key_q        <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				hcbe_pkg::REG_BLOCK_SIZE: block_size_q <= cfg_data[hcbe_pkg::BS_W-1:0];
				hcbe_pkg::REG_KEY_ROW0:   key_q[0] <= cfg_data;
				hcbe_pkg::REG_KEY_ROW1:   key_q[1] <= cfg_data;
				hcbe_pkg::REG_KEY_ROW2:   key_q[2] <= cfg_data;
				hcbe_pkg::REG_KEY_ROW3:   key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp block size into 1..MAX_BLOCK
	always_comb begin
		if (block_size_q == '0) begin
			blk_n = CNT_W'(1);
		end else if (int'(block_size_q) > MAX_BLOCK) begin
			blk_n = CNT_W'(MAX_BLOCK);
		end else begin
			blk_n = CNT_W'(block_size_q);
		end
	end

	assign key_rows = key_q;

endmodule
`default_nettype wire

@@ hdl/hcbe_ctrl.sv @@
// Controller state machine: letter intake, column compute and result handshake.
`default_nettype none
module hcbe_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	input  hcbe_pkg::dp_stat_t  stat,
	output hcbe_pkg::dp_cmd_t   cmd
);

	hcbe_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcbe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			hcbe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (stat.done) begin
						state_d = hcbe_pkg::ST_SUM;
					end
				end
			end
			hcbe_pkg::ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = hcbe_pkg::ST_RED;
			end
			hcbe_pkg::ST_RED: begin
				cmd.red_en = 1'b1;
				state_d    = hcbe_pkg::ST_SEND;
			end
			hcbe_pkg::ST_SEND: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.last_col) begin
						cmd.col_clr = 1'b1;
						state_d     = hcbe_pkg::ST_IDLE;
					end else begin
						cmd.col_inc = 1'b1;
						state_d     = hcbe_pkg::ST_SUM;
					end
				end
			end
			default: begin
				state_d = hcbe_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/hcbe_dp.sv @@
// Datapath: block buffer, column dot product and modulo-26 reduction.
`default_nettype none
module hcbe_dp #(
	parameter int MAX_BLOCK = 4,
	parameter int CNT_W     = $clog2(MAX_BLOCK + 1),
	parameter int COL_W     = $clog2(MAX_BLOCK)
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  hcbe_pkg::dp_cmd_t                cmd,
	output hcbe_pkg::dp_stat_t               stat,
	input  wire  [hcbe_pkg::LETTER_W-1:0]    in_letter,
	input  wire                              in_last,
	input  wire  [CNT_W-1:0]                 blk_n,
	input  hcbe_pkg::key_rows_t              key_rows,
	output logic [hcbe_pkg::LETTER_W-1:0]    out_letter,
	output logic                             out_last
);

	logic [hcbe_pkg::LETTER_W-1:0] buf_q [MAX_BLOCK];
	logic [CNT_W-1:0]              fill_q;
	logic [CNT_W-1:0]              fill_inc;
	logic [COL_W-1:0]              col_q;
	logic [hcbe_pkg::SUM_W-1:0]    sum_c;
	logic [hcbe_pkg::SUM_W-1:0]    sum_q;
	logic [hcbe_pkg::LETTER_W-1:0] elem;
	logic [hcbe_pkg::ENTRY_W-1:0]  kent;
	logic [hcbe_pkg::MUL_W-1:0]    prod;
	logic [hcbe_pkg::QUOT_W-1:0]   quot;
	logic [hcbe_pkg::SUM_W-1:0]    rem;
	logic [hcbe_pkg::LETTER_W-1:0] letter_q;
	logic                          last_q;

	assign fill_inc = (int'(fill_q) < MAX_BLOCK) ? fill_q + CNT_W'(1) : fill_q;

	assign stat.done     = (fill_inc >= blk_n) || in_last;
	assign stat.last_col = (CNT_W'(col_q) == blk_n - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			col_q  <= '0;
		end else begin
			if (cmd.take) begin
				fill_q <= fill_inc;
			end else if (cmd.col_clr) begin
				fill_q <= '0;
			end
			if (cmd.col_clr) begin
				col_q <= '0;
			end else if (cmd.col_inc) begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && (int'(fill_q) < MAX_BLOCK)) begin
			buf_q[fill_q[COL_W-1:0]] <= in_letter;
		end
	end

	// Slots past the fill level read as pad; rows past n contribute nothing
	always_comb begin
		sum_c = '0;
		elem  = '0;
		kent  = '0;
		for (int k = 0; k < MAX_BLOCK; k++) begin
			elem  = (CNT_W'(k) < fill_q) ? buf_q[k] : hcbe_pkg::PAD_LETTER;
			kent  = (CNT_W'(k) < blk_n) ?
				key_rows[k][col_q*hcbe_pkg::ENTRY_W +: hcbe_pkg::ENTRY_W] : '0;
			sum_c = sum_c + hcbe_pkg::SUM_W'(elem) * hcbe_pkg::SUM_W'(kent);
		end
	end

	// sum mod 26 via reciprocal multiply
	assign prod = hcbe_pkg::MUL_W'(sum_q) * hcbe_pkg::MUL_W'(hcbe_pkg::RECIP);
	assign quot = prod[hcbe_pkg::MUL_W-1:hcbe_pkg::RECIP_SHIFT];
	assign rem  = sum_q - hcbe_pkg::SUM_W'(quot) * hcbe_pkg::SUM_W'(hcbe_pkg::LETTER_MOD);

	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			sum_q <= sum_c;
		end
		if (cmd.red_en) begin
			letter_q <= rem[hcbe_pkg::LETTER_W-1:0];
			last_q   <= stat.last_col;
		end
	end

	assign out_letter = letter_q;
	assign out_last   = last_q;

endmodule
`default_nettype wire

@@ hdl/hill_cipher_block_encrypt_top.sv @@
// Top level of the Hill cipher block encryptor.
// Each letter is taken while the controller is idle; a letter that does not close a block leaves intake open.
// A closing block emits n results, each passing in turn through the column sum, mod-26 reduce
// and send states; the send state holds its result while the output stalls.
// Input is held off while a block's results are being produced by the shared column unit.
// Reset (arst_n low) empties the block, returns to idle, sets block size 2 and zero key.
`default_nettype none
module hill_cipher_block_encrypt_top #(
	parameter int MAX_BLOCK = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [2:0] cfg_index,
	input  wire  [19:0] cfg_data,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [7:0] s_axis_tdata,   // [4:0] letter
	input  wire        s_axis_tlast,   // message_end
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [4:0] out_letter
	output logic       m_axis_tlast    // block_last
);

	localparam int CNT_W = $clog2(MAX_BLOCK + 1);

	logic [CNT_W-1:0]              blk_n;
	hcbe_pkg::key_rows_t           key_rows;
	hcbe_pkg::dp_cmd_t             cmd;
	hcbe_pkg::dp_stat_t            stat;
	logic [hcbe_pkg::LETTER_W-1:0] out_letter;

	hcbe_cfg #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.blk_n     (blk_n),
		.key_rows  (key_rows)
	);

	hcbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	hcbe_dp #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_letter  (s_axis_tdata[hcbe_pkg::LETTER_W-1:0]),
		.in_last    (s_axis_tlast),
		.blk_n      (blk_n),
		.key_rows   (key_rows),
		.out_letter (out_letter),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {(hcbe_pkg::BYTE_W - hcbe_pkg::LETTER_W)'(0), out_letter};

endmodule
`default_nettype wire

@@ hdl/hcbe_chk.sv @@
// Port-level checker for the Hill cipher block encryptor, bound to the top level.
`default_nettype none
module hcbe_chk (
	input wire       clk,
	input wire       arst_n,
	input wire       s_axis_tready,
	input wire       m_axis_tvalid,
	input wire       m_axis_tready,
	input wire [7:0] m_axis_tdata,
	input wire       m_axis_tlast
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// Results are reduced letters
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata < 8'd26))
		else $error("result letter out of range");

	// Intake is closed while a block is being emitted
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_axis_tvalid && s_axis_tready))
		else $error("intake open during emission");

	// After a result is taken, valid stays low through the sum and reduce steps
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid ##1 !m_axis_tvalid)
		else $error("results too close together");

endmodule

bind hill_cipher_block_encrypt_top hcbe_chk u_hcbe_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

@@ test/hill_cipher_block_encrypt_top_tb.sv @@
// Self-checking testbench for the Hill cipher block encryptor: directed table, then random traffic.
module hill_cipher_block_encrypt_top_tb;
	import hcbe_pkg::*;

	localparam int MAX_BLK      = 4;
	localparam int RAND_ITEMS   = 350;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 200000;

	// indexes past key_row3 decode to nothing
	localparam logic [IDX_W-1:0] REG_VOID5 = IDX_W'(5);
	localparam logic [IDX_W-1:0] REG_VOID6 = IDX_W'(6);
	localparam logic [IDX_W-1:0] REG_VOID7 = IDX_W'(7);

	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                last;
	} cipher_out_t;

	typedef struct {
		bit                         is_cfg;
		logic [IDX_W-1:0]           idx;
		logic [ROW_W-1:0]           data;     // register value, or letter in the low bits
		logic                       msg_end;
		bit                         typed;
		int                         n_typed;
		logic [3:0][LETTER_W-1:0]   outs;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index;
	logic [ROW_W-1:0]   cfg_data;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [BYTE_W-1:0]  s_axis_tdata;
	logic               s_axis_tlast;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [BYTE_W-1:0]  m_axis_tdata;
	logic               m_axis_tlast;

	// shadow of the block's registers and block buffer
	logic [BS_W-1:0]      bs_reg = BLOCK_SIZE_RST;
	logic [ROW_W-1:0]     key_reg [KEY_ROWS];
	logic [LETTER_W-1:0]  blk_buf [MAX_BLK];
	int                   blk_fill = 0;

	cipher_out_t  expected_out [$];
	cipher_out_t  want;
	stim_row_t    stim_plan [$];
	int           err_count = 0;
	int           cycles = 0;
	bit           no_idle = 1'b0;

	hill_cipher_block_encrypt_top #(
		.MAX_BLOCK(MAX_BLK)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
		err_count++;
	endtask

	// Take one letter into the shadow block; return the letters of a closed block.
	function automatic void cipher_predict(input logic [LETTER_W-1:0] letter, input logic msg_end,
			output cipher_out_t [3:0] res, output int n_res);
		int n, j, k, acc;
		if (bs_reg == 0)
			n = 1;
		else if (bs_reg > MAX_BLK)
			n = MAX_BLK;
		else
			n = int'(bs_reg);
		res = '0;
		n_res = 0;
		if (blk_fill < MAX_BLK) begin
			blk_buf[blk_fill] = letter;
			blk_fill++;
		end
		if (blk_fill >= n || msg_end) begin
			for (k = blk_fill; k < n; k++)
				blk_buf[k] = PAD_LETTER;
			for (j = 0; j < n; j++) begin
				acc = 0;
				for (k = 0; k < n; k++)
					acc += int'(blk_buf[k]) * int'(key_reg[k][ENTRY_W*j +: ENTRY_W]);
				res[j].letter = LETTER_W'(acc % int'(LETTER_MOD));
				res[j].last = (j == n - 1);
			end
			// anything past n letters is dropped
			blk_fill = 0;
			n_res = n;
		end
	endfunction

	function automatic void add_cfg(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
		stim_row_t r;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		r.msg_end = 1'b0;
		r.typed = 1'b0;
		r.n_typed = 0;
		r.outs = '0;
		stim_plan.push_back(r);
	endfunction

	function automatic void add_typed(input logic [LETTER_W-1:0] letter, input logic msg_end,
			input int n_typed, input logic [3:0][LETTER_W-1:0] outs);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.idx = '0;
		r.data = ROW_W'(letter);
		r.msg_end = msg_end;
		r.typed = 1'b1;
		r.n_typed = n_typed;
		r.outs = outs;
		stim_plan.push_back(r);
	endfunction

	function automatic void add_letter(input logic [LETTER_W-1:0] letter, input logic msg_end);
		add_typed(letter, msg_end, 0, '0);
		stim_plan[$].typed = 1'b0;
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_BLOCK_SIZE: bs_reg = val[BS_W-1:0];
			REG_KEY_ROW0:   key_reg[0] = val;
			REG_KEY_ROW1:   key_reg[1] = val;
			REG_KEY_ROW2:   key_reg[2] = val;
			REG_KEY_ROW3:   key_reg[3] = val;
			default: ;
		endcase
	endtask

	task automatic send_item(input stim_row_t row);
		cipher_out_t [3:0] res;
		cipher_out_t t;
		int n, j;
		while (!no_idle && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, row.data[LETTER_W-1:0]};
		s_axis_tlast <= row.msg_end;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		cipher_predict(row.data[LETTER_W-1:0], row.msg_end, res, n);
		if (row.typed) begin
			for (j = 0; j < row.n_typed; j++) begin
				t.letter = row.outs[j];
				t.last = (j == row.n_typed - 1);
				expected_out.push_back(t);
			end
		end else begin
			for (j = 0; j < n; j++)
				expected_out.push_back(res[j]);
		end
	endtask

	// block must be idle before a register write
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
				if (expected_out.size() == 0) begin
					report_mismatch("request with nothing pending", int'(m_axis_tdata), -1);
				end else begin
					want = expected_out.pop_front();
					if (m_axis_tdata[LETTER_W-1:0] !== want.letter)
						report_mismatch("out_letter", int'(m_axis_tdata[LETTER_W-1:0]),
							int'(want.letter));
					if (m_axis_tlast !== want.last)
						report_mismatch("block_last", int'(m_axis_tlast), int'(want.last));
				end
			end
			m_axis_tready <= no_idle || ($urandom_range(99) >= 22);
		end
	end

	initial begin : stim
		stim_row_t r;
		logic [ROW_W-1:0] kv;
		bit prev_cfg;
		bit first;
		int rand_sent;
		int burst;
		int i, k;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		for (k = 0; k < KEY_ROWS; k++)
			key_reg[k] = '0;
		for (k = 0; k < MAX_BLK; k++)
			blk_buf[k] = '0;

		// after reset: block size 2, zero key, so every output is a
		add_typed(5'd0, 1'b0, 0, '0);
		add_typed(5'd31, 1'b0, 2, '0);
		add_typed(5'd25, 1'b1, 2, '0);     // short block padded
		add_typed(5'd0, 1'b1, 2, '0);
		// identity key, 4x4
		add_cfg(REG_KEY_ROW0, 20'h00001);
		add_cfg(REG_KEY_ROW1, 20'h00020);
		add_cfg(REG_KEY_ROW2, 20'h00400);
		add_cfg(REG_KEY_ROW3, 20'h08000);
		add_cfg(REG_BLOCK_SIZE, 20'd4);
		add_typed(5'd0, 1'b0, 0, '0);
		add_typed(5'd25, 1'b0, 0, '0);
		add_typed(5'd12, 1'b0, 0, '0);
		add_typed(5'd7, 1'b0, 4, {5'd7, 5'd12, 5'd25, 5'd0});
		add_typed(5'd3, 1'b1, 4, {5'd25, 5'd25, 5'd25, 5'd3});
		// size 0 acts as 1, all key bits set
		add_cfg(REG_BLOCK_SIZE, 20'd0);
		add_cfg(REG_KEY_ROW0, 20'hFFFFF);
		add_cfg(REG_KEY_ROW1, 20'hFFFFF);
		add_cfg(REG_KEY_ROW2, 20'hFFFFF);
		add_cfg(REG_KEY_ROW3, 20'hFFFFF);
		add_letter(5'd31, 1'b0);
		add_letter(5'd0, 1'b1);
		// size 7 acts as 4; largest column sum
		add_cfg(REG_BLOCK_SIZE, 20'd7);
		for (k = 0; k < 4; k++)
			add_letter(5'd31, 1'b0);
		add_letter(5'd26, 1'b1);
		// size 3, then lowered to 1 with two letters held
		add_cfg(REG_BLOCK_SIZE, 20'd3);
		add_cfg(REG_KEY_ROW0, 20'h3_2C51);
		add_cfg(REG_KEY_ROW1, 20'hA_1B07);
		add_cfg(REG_KEY_ROW2, 20'h5_6E93);
		add_letter(5'd5, 1'b0);
		add_letter(5'd6, 1'b0);
		add_cfg(REG_BLOCK_SIZE, 20'd1);
		add_letter(5'd7, 1'b0);
		// writes to unused indexes leave the key alone
		add_cfg(REG_VOID5, 20'hFFFFF);
		add_cfg(REG_VOID6, 20'h00000);
		add_cfg(REG_VOID7, 20'hFFFFF);
		add_cfg(REG_BLOCK_SIZE, 20'd2);
		add_letter(5'd9, 1'b1);
		add_letter(5'd17, 1'b0);
		add_letter(5'd2, 1'b0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_cfg = 1'b0;
		foreach (stim_plan[i]) begin
			if (stim_plan[i].is_cfg) begin
				if (!prev_cfg)
					wait_drained();
				write_reg(stim_plan[i].idx, stim_plan[i].data);
			end else begin
				send_item(stim_plan[i]);
			end
			prev_cfg = stim_plan[i].is_cfg;
		end

		r.is_cfg = 1'b0;
		r.idx = '0;
		r.typed = 1'b0;
		r.n_typed = 0;
		r.outs = '0;
		rand_sent = 0;
		first = 1'b1;
		while (rand_sent < RAND_ITEMS) begin
			wait_drained();
			// partial blocks stay held across a reconfigure
			if (first || $urandom_range(9) < 6) begin
				if ($urandom_range(9) < 7)
					write_reg(REG_BLOCK_SIZE, ROW_W'($urandom_range(4, 1)));
				else
					write_reg(REG_BLOCK_SIZE, ROW_W'($urandom_range(7)));
			end
			for (k = 0; k < KEY_ROWS; k++) begin
				if (first || $urandom_range(9) < 4) begin
					case ($urandom_range(9))
						0: kv = '0;
						1: kv = '1;
						2: kv = ROW_W'($urandom_range(20'hFFFFF));
						default: begin
							for (i = 0; i < 4; i++)
								kv[ENTRY_W*i +: ENTRY_W] = ENTRY_W'($urandom_range(25));
						end
					endcase
					write_reg(REG_KEY_ROW0 + IDX_W'(k), kv);
				end
			end
			if ($urandom_range(9) == 0)
				write_reg(IDX_W'($urandom_range(REG_VOID7, REG_VOID5)),
					ROW_W'($urandom_range(20'hFFFFF)));
			first = 1'b0;
			burst = $urandom_range(40, 4);
			for (i = 0; i < burst && rand_sent < RAND_ITEMS; i++) begin
				no_idle <= (rand_sent >= 120 && rand_sent < 200);
				if ($urandom_range(7) == 0)
					r.data = ROW_W'($urandom_range(31));
				else
					r.data = ROW_W'($urandom_range(25));
				r.msg_end = ($urandom_range(99) < 12);
				send_item(r);
				rand_sent++;
			end
		end

		wait_drained();
		if (err_count == 0 && expected_out.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
